@@ design/fic_pkg.sv @@
`timescale 1ns / 1ps

package fic_pkg;

	localparam int RING_DEPTH = 512;
	localparam int PTR_W      = $clog2(RING_DEPTH);
	localparam int MAX_BURST  = 64;
	localparam int LIMIT_W    = 7;
	localparam int CNT_W      = $clog2(MAX_BURST);
	localparam int TIME_W     = 16;
	localparam int FILL_W     = 9;
	localparam int OP_W       = 3;
	localparam int IN_W       = 32;
	localparam int OUT_W      = 48;

	localparam logic [OP_W-1:0] OP_EDGE  = 3'd0;
	localparam logic [OP_W-1:0] OP_POP   = 3'd1;
	localparam logic [OP_W-1:0] OP_START = 3'd2;
	localparam logic [OP_W-1:0] OP_STOP  = 3'd3;
	localparam logic [OP_W-1:0] OP_CLEAR = 3'd4;

	typedef logic [PTR_W-1:0] ptr_t;

	function automatic ptr_t ptr_inc(input ptr_t p);
		if (p == PTR_W'(RING_DEPTH - 1)) begin
			return '0;
		end
		return p + PTR_W'(1);
	endfunction

	function automatic logic [FILL_W-1:0] ring_fill(input ptr_t wr, input ptr_t rd);
		logic [PTR_W:0] full;
		if (wr >= rd) begin
			full = {1'b0, wr} - {1'b0, rd};
		end else begin
			full = (PTR_W+1)'(RING_DEPTH) - {1'b0, rd} + {1'b0, wr};
		end
		return FILL_W'(full);
	endfunction

endpackage

@@ design/flux_interval_capture_fifo.sv @@
`timescale 1ns / 1ps

// flux interval capture fifo
// input channel s_*: one command beat per item (flux edge, pop burst, start,
// stop, buffer reset). output channel m_*: result beats, m_tlast on the
// final beat caused by a command, m_tuser set when the beat carries an
// interval popped from the ring.
// a command other than a pop burst is taken at once; its status beat
// is registered and shows on m_* the cycle after acceptance, and the next
// command may be taken in that same cycle if the output is free or drained.
// a pop burst holds s_tready low until its last interval is loaded into
// the result register: the synchronous ring read is issued at acceptance
// into rd_data_s1, then each interval moves on to the result register and
// m_*, one beat per cycle while m_tready holds, paced by the ring read loop.
// when m_tready is low the result register holds its beat and no further
// command or ring read proceeds until the beat is taken.
// reset clears pointers, flags, counter and the output valid; ring contents
// are not cleared, since only written entries ever lie between the pointers.
module flux_interval_capture_fifo import fic_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,   // opcode[2:0], timer_now[18:3], read_limit[25:19]
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata,   // read_data[15:0], fill_level[24:16],
	                                    // overflow_count[40:25], capturing[41]
	output logic             m_tlast,
	output logic             m_tuser    // data_valid
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EMIT = 1'b1;

	logic [TIME_W-1:0] ring [RING_DEPTH];
	logic [TIME_W-1:0] rd_data_s1;

	logic              state_q;
	ptr_t              wr_ptr_q, rd_ptr_q;
	logic [TIME_W-1:0] prev_time_q;
	logic              armed_q, capture_q;
	logic [TIME_W-1:0] dropped_q;
	logic [CNT_W-1:0]  cnt_q;

	logic [TIME_W-1:0] out_data_q;
	logic [FILL_W-1:0] out_fill_q;
	logic [TIME_W-1:0] out_drop_q;
	logic              out_cap_q, out_last_q, out_dv_q, out_valid_q;

	logic [OP_W-1:0]    op;
	logic [TIME_W-1:0]  now;
	logic [LIMIT_W-1:0] limit, limit_eff;
	logic               out_free, accept, burst_start;
	logic               ring_we, ring_re, emit_last;
	ptr_t               wr_nxt, rd_nxt, wr_inc;
	logic [TIME_W-1:0]  prev_nxt, dropped_nxt;
	logic               armed_nxt, capture_nxt;

	assign op    = s_tdata[OP_W-1:0];
	assign now   = s_tdata[OP_W+TIME_W-1:OP_W];
	assign limit = s_tdata[OP_W+TIME_W+LIMIT_W-1:OP_W+TIME_W];

	assign limit_eff = (limit > LIMIT_W'(MAX_BURST)) ? LIMIT_W'(MAX_BURST) : limit;
	assign out_free  = !out_valid_q || m_tready;
	assign s_tready  = (state_q == ST_IDLE) && out_free;
	assign accept    = s_tvalid && s_tready;
	assign wr_inc    = ptr_inc(wr_ptr_q);

	assign burst_start = accept && (op == OP_POP) && (limit_eff != '0)
		&& (rd_ptr_q != wr_ptr_q);
	assign emit_last   = (cnt_q == '0) || (rd_ptr_q == wr_ptr_q);
	assign ring_re     = burst_start
		|| ((state_q == ST_EMIT) && out_free && !emit_last);

	always_comb begin
		wr_nxt      = wr_ptr_q;
		rd_nxt      = rd_ptr_q;
		prev_nxt    = prev_time_q;
		armed_nxt   = armed_q;
		capture_nxt = capture_q;
		dropped_nxt = dropped_q;
		ring_we     = 1'b0;
		if (accept) begin
			case (op)
				OP_EDGE: begin
					if (capture_q) begin
						if (armed_q) begin
							if (wr_inc != rd_ptr_q) begin
								ring_we = 1'b1;
								wr_nxt  = wr_inc;
							end else begin
								dropped_nxt = dropped_q + TIME_W'(1);
							end
						end else begin
							armed_nxt = 1'b1;
						end
						prev_nxt = now;
					end
				end
				OP_START: begin
					capture_nxt = 1'b1;
					armed_nxt   = 1'b0;
					prev_nxt    = now;
				end
				OP_STOP: begin
					capture_nxt = 1'b0;
					armed_nxt   = 1'b0;
				end
				OP_CLEAR: begin
					wr_nxt      = '0;
					rd_nxt      = '0;
					prev_nxt    = now;
					armed_nxt   = 1'b0;
					dropped_nxt = '0;
				end
				default: begin
				end
			endcase
		end
		if (ring_re) begin
			rd_nxt = ptr_inc(rd_ptr_q);
		end
	end

	always_ff @(posedge clk) begin
		if (ring_we) begin
			ring[wr_ptr_q] <= now - prev_time_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ring_re) begin
			rd_data_s1 <= ring[rd_ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wr_ptr_q    <= '0;
			rd_ptr_q    <= '0;
			prev_time_q <= '0;
			armed_q     <= 1'b0;
			capture_q   <= 1'b0;
			dropped_q   <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			wr_ptr_q    <= wr_nxt;
			rd_ptr_q    <= rd_nxt;
			prev_time_q <= prev_nxt;
			armed_q     <= armed_nxt;
			capture_q   <= capture_nxt;
			dropped_q   <= dropped_nxt;
			if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (burst_start) begin
						state_q <= ST_EMIT;
						cnt_q   <= CNT_W'(limit_eff - LIMIT_W'(1));
					end else if (accept) begin
						out_valid_q <= 1'b1;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						if (emit_last) begin
							state_q <= ST_IDLE;
						end else begin
							cnt_q <= cnt_q - CNT_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			if (accept && !burst_start) begin
				out_data_q <= '0;
				out_dv_q   <= 1'b0;
				out_last_q <= 1'b1;
				out_fill_q <= ring_fill(wr_nxt, rd_nxt);
				out_drop_q <= dropped_nxt;
				out_cap_q  <= capture_nxt;
			end
		end else if (out_free) begin
			out_data_q <= rd_data_s1;
			out_dv_q   <= 1'b1;
			out_last_q <= emit_last;
			out_fill_q <= ring_fill(wr_ptr_q, rd_ptr_q);
			out_drop_q <= dropped_q;
			out_cap_q  <= capture_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_dv_q;
	assign m_tdata  = {(OUT_W-TIME_W-FILL_W-TIME_W-1)'(0), out_cap_q, out_drop_q,
		out_fill_q, out_data_q};

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
	import fic_pkg::*;

	localparam logic [OP_W-1:0] OP_RSVD5 = 3'd5;
	localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
	localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;
	localparam int WATCHDOG_LIMIT = 1000;

	typedef struct packed {
		logic [TIME_W-1:0] interval;
		logic              data_valid;
		logic              last;
		logic [FILL_W-1:0] fill;
		logic [15:0]       dropped;
		logic              capturing;
	} capture_beat_t;

	typedef struct packed {
		logic [OP_W-1:0]    op;
		logic [TIME_W-1:0]  now;
		logic [LIMIT_W-1:0] lim;
		logic               typed;
		capture_beat_t      want;
	} dir_row_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata = '0;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;
	logic             m_tlast;
	logic             m_tuser;

	flux_interval_capture_fifo u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// capture model state
	logic [TIME_W-1:0] ring_mem [RING_DEPTH];
	int unsigned       wr_idx = 0;
	int unsigned       rd_idx = 0;
	logic [TIME_W-1:0] last_edge = '0;
	logic              armed = 1'b0;
	logic              capt_en = 1'b0;
	logic [15:0]       drop_cnt = '0;

	capture_beat_t expected_capture_beats [$];
	capture_beat_t typed_beat = '0;
	bit            typed_armed = 1'b0;
	int            mismatches = 0;
	int            quiet_cycles = 0;
	bit            gap_on = 1'b1;
	bit            stall_on = 1'b1;
	logic [15:0]   flux_tick = '0;

	dir_row_t dir_rows [0:23] = '{
		'{OP_EDGE,  16'h1234, 7'd0,   1'b1, '{16'h0000, 1'b0, 1'b1, 9'd0, 16'd0, 1'b0}},
		'{OP_POP,   16'h0000, 7'd5,   1'b1, '{16'h0000, 1'b0, 1'b1, 9'd0, 16'd0, 1'b0}},
		'{OP_RSVD5, 16'hFFFF, 7'd127, 1'b1, '{16'h0000, 1'b0, 1'b1, 9'd0, 16'd0, 1'b0}},
		'{OP_RSVD7, 16'h5555, 7'd64,  1'b1, '{16'h0000, 1'b0, 1'b1, 9'd0, 16'd0, 1'b0}},
		'{OP_START, 16'h0000, 7'd0,   1'b1, '{16'h0000, 1'b0, 1'b1, 9'd0, 16'd0, 1'b1}},
		'{OP_EDGE,  16'hFFFF, 7'd0,   1'b1, '{16'h0000, 1'b0, 1'b1, 9'd0, 16'd0, 1'b1}},
		'{OP_EDGE,  16'h0000, 7'd0,   1'b1, '{16'h0000, 1'b0, 1'b1, 9'd1, 16'd0, 1'b1}},
		'{OP_EDGE,  16'hFFFF, 7'd0,   1'b1, '{16'h0000, 1'b0, 1'b1, 9'd2, 16'd0, 1'b1}},
		'{OP_EDGE,  16'hFFFF, 7'd0,   1'b1, '{16'h0000, 1'b0, 1'b1, 9'd3, 16'd0, 1'b1}},
		'{OP_POP,   16'h0000, 7'd0,   1'b1, '{16'h0000, 1'b0, 1'b1, 9'd3, 16'd0, 1'b1}},
		'{OP_POP,   16'h0000, 7'd1,   1'b1, '{16'h0001, 1'b1, 1'b1, 9'd2, 16'd0, 1'b1}},
		'{OP_POP,   16'h0000, 7'd127, 1'b0, '0},
		'{OP_STOP,  16'hAAAA, 7'd0,   1'b1, '{16'h0000, 1'b0, 1'b1, 9'd0, 16'd0, 1'b0}},
		'{OP_EDGE,  16'h1000, 7'd0,   1'b1, '{16'h0000, 1'b0, 1'b1, 9'd0, 16'd0, 1'b0}},
		'{OP_START, 16'h0100, 7'd0,   1'b1, '{16'h0000, 1'b0, 1'b1, 9'd0, 16'd0, 1'b1}},
		'{OP_EDGE,  16'h0180, 7'd0,   1'b1, '{16'h0000, 1'b0, 1'b1, 9'd0, 16'd0, 1'b1}},
		'{OP_EDGE,  16'h0300, 7'd0,   1'b0, '0},
		'{OP_EDGE,  16'h0400, 7'd0,   1'b0, '0},
		'{OP_CLEAR, 16'h2AAA, 7'd127, 1'b1, '{16'h0000, 1'b0, 1'b1, 9'd0, 16'd0, 1'b1}},
		'{OP_EDGE,  16'h2AAB, 7'd0,   1'b0, '0},
		'{OP_EDGE,  16'h5555, 7'd0,   1'b0, '0},
		'{OP_RSVD6, 16'h7FFF, 7'd42,  1'b0, '0},
		'{OP_POP,   16'h0000, 7'd64,  1'b0, '0},
		'{OP_STOP,  16'h0000, 7'd0,   1'b0, '0}
	};

	function automatic capture_beat_t capture_beat(input logic [TIME_W-1:0] value,
			input logic valid, input logic last);
		capture_beat_t b;
		b.interval   = valid ? value : '0;
		b.data_valid = valid;
		b.last       = last;
		b.fill       = FILL_W'((wr_idx + RING_DEPTH - rd_idx) % RING_DEPTH);
		b.dropped    = drop_cnt;
		b.capturing  = capt_en;
		return b;
	endfunction

	function automatic void predict_capture_beats(input logic [OP_W-1:0] op,
			input logic [TIME_W-1:0] now, input logic [LIMIT_W-1:0] lim);
		int unsigned       nxt;
		int unsigned       burst;
		int unsigned       popped;
		logic [TIME_W-1:0] held;
		popped = 0;
		case (op)
			OP_EDGE: begin
				if (capt_en) begin
					if (armed) begin
						nxt = (wr_idx + 1) % RING_DEPTH;
						if (nxt != rd_idx) begin
							ring_mem[wr_idx] = now - last_edge;
							wr_idx = nxt;
						end else begin
							drop_cnt = drop_cnt + 16'd1;
						end
					end else begin
						armed = 1'b1;
					end
					last_edge = now;
				end
			end
			OP_POP: begin
				burst = (lim > MAX_BURST) ? MAX_BURST : lim;
				while (popped < burst && rd_idx != wr_idx) begin
					held = ring_mem[rd_idx];
					rd_idx = (rd_idx + 1) % RING_DEPTH;
					popped++;
					expected_capture_beats.push_back(capture_beat(held, 1'b1,
						popped == burst || rd_idx == wr_idx));
				end
			end
			OP_START: begin
				capt_en = 1'b1;
				armed = 1'b0;
				last_edge = now;
			end
			OP_STOP: begin
				capt_en = 1'b0;
				armed = 1'b0;
			end
			OP_CLEAR: begin
				wr_idx = 0;
				rd_idx = 0;
				last_edge = now;
				armed = 1'b0;
				drop_cnt = '0;
			end
			default: ;
		endcase
		if (popped == 0) begin
			expected_capture_beats.push_back(capture_beat('0, 1'b0, 1'b1));
		end
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch at %0t: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk) begin
		capture_beat_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_capture_beats.size() == 0) begin
					report_mismatch("beat with nothing pending", m_tdata, 0);
				end else begin
					want = expected_capture_beats.pop_front();
					if (m_tdata[15:0] != want.interval)
						report_mismatch("read_data", m_tdata[15:0], want.interval);
					if (m_tuser != want.data_valid)
						report_mismatch("data_valid", m_tuser, want.data_valid);
					if (m_tlast != want.last)
						report_mismatch("last_of_run", m_tlast, want.last);
					if (m_tdata[24:16] != want.fill)
						report_mismatch("fill_level", m_tdata[24:16], want.fill);
					if (m_tdata[40:25] != want.dropped)
						report_mismatch("overflow_count", m_tdata[40:25], want.dropped);
					if (m_tdata[41] != want.capturing)
						report_mismatch("capturing", m_tdata[41], want.capturing);
				end
			end
			if (s_tvalid && s_tready) begin
				predict_capture_beats(s_tdata[2:0], s_tdata[18:3], s_tdata[25:19]);
				if (typed_armed) begin
					void'(expected_capture_beats.pop_back());
					expected_capture_beats.push_back(typed_beat);
					typed_armed = 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("flux_interval_capture_fifo test failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// receiver stalls at random, holding m_tready low in bursts
	initial begin
		forever begin
			@(negedge clk);
			if (stall_on && $urandom_range(0, 7) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(0, 13)) @(negedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic send_cmd(input logic [OP_W-1:0] op, input logic [TIME_W-1:0] now,
			input logic [LIMIT_W-1:0] lim, input bit typed, input capture_beat_t want);
		@(negedge clk);
		typed_armed = typed;
		typed_beat = want;
		if (gap_on && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {6'b0, lim, now, op};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic wait_results_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_capture_beats.size() != 0) @(negedge clk);
	endtask

	task automatic send_random_cmd();
		logic [OP_W-1:0]    op;
		logic [TIME_W-1:0]  now;
		logic [LIMIT_W-1:0] lim;
		int                 pick;
		pick = $urandom_range(0, 99);
		if (pick < 50)
			op = OP_EDGE;
		else if (pick < 72)
			op = OP_POP;
		else if (pick < 82)
			op = OP_START;
		else if (pick < 88)
			op = OP_STOP;
		else if (pick < 94)
			op = OP_CLEAR;
		else
			op = (pick < 96) ? OP_RSVD5 : (pick < 98) ? OP_RSVD6 : OP_RSVD7;
		if ($urandom_range(0, 7) == 0) begin
			now = 16'($urandom);
		end else begin
			flux_tick += 16'($urandom_range(1, 900));
			now = flux_tick;
		end
		if ($urandom_range(0, 7) == 0)
			lim = 7'($urandom_range(0, 127));
		else
			lim = 7'($urandom_range(1, MAX_BURST));
		send_cmd(op, now, lim, 1'b0, '0);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			send_cmd(dir_rows[i].op, dir_rows[i].now, dir_rows[i].lim, dir_rows[i].typed,
				dir_rows[i].want);
		end

		repeat (70) send_random_cmd();

		wait_results_drained();

		send_cmd(OP_START, flux_tick, 7'd0, 1'b0, '0);
		repeat (60) send_random_cmd();
		gap_on = 1'b0;
		stall_on = 1'b0;
		repeat (50) send_random_cmd();

		wait_results_drained();
		repeat (20) @(posedge clk);
		if (mismatches == 0) begin
			$display("flux_interval_capture_fifo test passed");
		end else begin
			$display("flux_interval_capture_fifo test failed");
		end
		$finish;
	end

endmodule
